[rtl/core/tts_pkg.sv]
// Shared types and constants for the time-triggered task scheduler.
`default_nettype none

package tts_pkg;

  // Table size and derived widths.
  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths.
  localparam int DELAY_W   = 15;
  localparam int PERIOD_W  = 15;
  localparam int ELAPSED_W = 16;
  localparam int IDLE_W    = 16;
  localparam int REM_W     = 32;
  localparam int INDEX_W   = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Saturation and clamp values.
  localparam logic [REM_W-1:0]  REM_MIN  = {1'b1, {(REM_W-1){1'b0}}};
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  // Request kinds carried on the input tuser line.
  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  // Slot write issued by the top level for an add request.
  typedef struct packed {
    logic                en;
    logic [DELAY_W-1:0]  delay;
    logic [PERIOD_W-1:0] period;
  } wr_t;

  // Dispatch token walking along the row of slot cells.
  typedef struct packed {
    logic                 valid;
    logic [ELAPSED_W-1:0] elapsed;
    logic [IDX_W-1:0]     pos;
    logic                 fired;
    logic [IDX_W-1:0]     idx;
    logic                 any_due;
    logic [IDLE_W-1:0]    best;
  } tok_t;

endpackage

`default_nettype wire

[rtl/core/tts_cell.sv]
// One task slot of the scheduler table, processing a dispatch token and registering it for the next cell.
`default_nettype none

module tts_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tts_pkg::wr_t  wr_i,
  input  wire tts_pkg::tok_t tok_i,
  output tts_pkg::tok_t      tok_o
);

  logic                          running_q;
  logic [tts_pkg::REM_W-1:0]     rem_q;
  logic [tts_pkg::PERIOD_W-1:0]  period_q;
  tts_pkg::tok_t                 tok_q, tok_d;

  logic [tts_pkg::REM_W:0]       diff;
  logic                          sat;
  logic [tts_pkg::REM_W-1:0]     rem_sub;
  logic                          due;
  logic                          take;
  logic [tts_pkg::REM_W-1:0]     rem_d;
  logic [tts_pkg::IDLE_W-1:0]    rem_clamp;
  logic                          better;

  // Subtract elapsed time with saturation at the most negative value.
  always_comb begin
    diff    = {rem_q[tts_pkg::REM_W-1], rem_q}
              - {{(tts_pkg::REM_W + 1 - tts_pkg::ELAPSED_W){1'b0}}, tok_i.elapsed};
    sat     = diff[tts_pkg::REM_W] & ~diff[tts_pkg::REM_W-1];
    rem_sub = sat ? tts_pkg::REM_MIN : diff[tts_pkg::REM_W-1:0];
    due     = rem_sub[tts_pkg::REM_W-1] | (rem_sub == '0);
    take    = running_q & due & ~tok_i.fired;
    rem_d   = take ? rem_sub + {{(tts_pkg::REM_W - tts_pkg::PERIOD_W){1'b0}}, period_q}
                   : rem_sub;
    rem_clamp = (rem_sub[tts_pkg::REM_W-1:tts_pkg::IDLE_W] != '0) ? tts_pkg::IDLE_MAX
                                                                  : rem_sub[tts_pkg::IDLE_W-1:0];
    better  = running_q & ~due & (rem_clamp < tok_i.best);
  end

  // Token handed to the next cell.
  always_comb begin
    tok_d         = tok_i;
    tok_d.pos     = tok_i.pos + tts_pkg::IDX_W'(1);
    tok_d.fired   = tok_i.fired | take;
    tok_d.idx     = take ? tok_i.pos : tok_i.idx;
    tok_d.any_due = tok_i.any_due | (running_q & due);
    tok_d.best    = better ? rem_clamp : tok_i.best;
  end

  // Running flag and token register are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      if (wr_i.en) begin
        running_q <= 1'b1;
      end
      tok_q <= tok_d;
    end
  end

  // Slot payload loads when written; the remaining time also updates as a dispatch token passes a running slot.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rem_q    <= {{(tts_pkg::REM_W - tts_pkg::DELAY_W){1'b0}}, wr_i.delay};
      period_q <= wr_i.period;
    end else if (tok_i.valid && running_q) begin
      rem_q <= rem_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[rtl/core/time_triggered_task_scheduler.sv]
// Top level of the time-triggered task scheduler: slot cell row, add logic, result register.
//
//  Channel  Direction  Payload
//  s_axis   in         tuser: operation; tdata: start_delay, period_ms, elapsed_ms
//  m_axis   out        tdata: add_failed, task_fired, fired_index, idle_ms
//
//  An add request is answered in the cycle after it is taken. A dispatch request launches a
//  token that walks the row of slot cells, one cell per cycle; its result is registered after the last cell.
//  One request is in flight at a time; a new one is taken once the result register
//  is empty or being drained in the same cycle.
//  Reset clears all running flags and the slot count; slot contents need no reset.
//  A stalled result holds in the output register until m_axis_tready is high.
`default_nettype none

module time_triggered_task_scheduler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [14:0] start_delay, [29:15] period_ms, [45:30] elapsed_ms, [47:46] zero
  input  wire logic [tts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] add_failed, [1] task_fired, [4:2] fired_index, [20:5] idle_ms, [23:21] zero
  output logic [tts_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int D_LO = 0;
  localparam int P_LO = D_LO + tts_pkg::DELAY_W;
  localparam int E_LO = P_LO + tts_pkg::PERIOD_W;

  logic [tts_pkg::DELAY_W-1:0]   in_delay;
  logic [tts_pkg::PERIOD_W-1:0]  in_period;
  logic [tts_pkg::ELAPSED_W-1:0] in_elapsed;
  tts_pkg::op_e                  in_op;
  logic                          in_acc;
  logic                          add_acc;
  logic                          full;

  logic                          busy_q, busy_d;
  logic [tts_pkg::CNT_W-1:0]     next_slot_q, next_slot_d;
  logic                          out_valid_q, out_valid_d;
  logic [tts_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  tts_pkg::tok_t                 tok [tts_pkg::MAX_TASKS+1];
  tts_pkg::wr_t                  wr  [tts_pkg::MAX_TASKS];
  tts_pkg::tok_t                 last_tok;
  logic [tts_pkg::IDX_W+tts_pkg::INDEX_W-1:0] idx_ext;
  logic [tts_pkg::MAX_TASKS-1:0] tok_valids;

  // Input unpacking and handshake.
  assign in_delay   = s_axis_tdata[D_LO +: tts_pkg::DELAY_W];
  assign in_period  = s_axis_tdata[P_LO +: tts_pkg::PERIOD_W];
  assign in_elapsed = s_axis_tdata[E_LO +: tts_pkg::ELAPSED_W];
  assign in_op      = tts_pkg::op_e'(s_axis_tuser);

  assign s_axis_tready = ~busy_q & (~out_valid_q | m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign add_acc       = in_acc & (in_op == tts_pkg::OP_ADD);
  assign full          = (next_slot_q == tts_pkg::CNT_W'(tts_pkg::MAX_TASKS));

  // Token launched into the first cell on a dispatch request.
  always_comb begin
    tok[0].valid   = in_acc & (in_op == tts_pkg::OP_DISPATCH);
    tok[0].elapsed = in_elapsed;
    tok[0].pos     = '0;
    tok[0].fired   = 1'b0;
    tok[0].idx     = '0;
    tok[0].any_due = 1'b0;
    tok[0].best    = tts_pkg::IDLE_MAX;
  end

  // Row of slot cells.
  for (genvar k = 0; k < tts_pkg::MAX_TASKS; k++) begin : g_cell
    always_comb begin
      wr[k].en     = add_acc & ~full & (next_slot_q == tts_pkg::CNT_W'(k));
      wr[k].delay  = in_delay;
      wr[k].period = in_period;
    end

    tts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr[k]),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );

    assign tok_valids[k] = tok[k+1].valid;
  end

  assign last_tok = tok[tts_pkg::MAX_TASKS];
  assign idx_ext  = {{tts_pkg::INDEX_W{1'b0}}, last_tok.idx};

  // Control next state: busy flag, slot count, result register.
  always_comb begin
    busy_d      = busy_q;
    next_slot_d = next_slot_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end
    if (add_acc) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_data_d[0] = full;
      if (!full) begin
        next_slot_d = next_slot_q + tts_pkg::CNT_W'(1);
      end
    end
    if (last_tok.valid) begin
      busy_d        = 1'b0;
      out_valid_d   = 1'b1;
      out_data_d    = '0;
      out_data_d[1] = last_tok.fired;
      out_data_d[4:2] = idx_ext[tts_pkg::INDEX_W-1:0];
      out_data_d[5 +: tts_pkg::IDLE_W] = last_tok.any_due ? '0 : last_tok.best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      next_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      next_slot_q <= next_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Only one dispatch token is ever in the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_valids))
    else $error("more than one dispatch token in the cell row");

  // A token in the row means the block is busy and takes no request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valids != '0) |-> (busy_q && !s_axis_tready))
    else $error("request taken while a dispatch is in progress");

  // The slot count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= tts_pkg::CNT_W'(tts_pkg::MAX_TASKS))
    else $error("slot count beyond table size");

  // A dispatch request puts a token into the first cell on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[0].valid |=> tok[1].valid)
    else $error("dispatch token lost at the first cell");

  // A result never reports both an add failure and a fired task.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("result mixes add and dispatch flags");

endmodule

`default_nettype wire
